// ===== rtl/yuv2rgba_pkg.sv =====
// Shared types and coefficients for the BT.601 YUV to RGBA pixel converter.
`default_nettype none

package yuv2rgba_pkg;

  // Widths of the internal fixed-point datapath.
  localparam int PROD_W = 18;   // one coefficient times an offset sample
  localparam int SUM_W  = 19;   // sum of up to three products plus rounding
  localparam int RES_W  = 12;   // rounded component before saturation

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // 8.8 coefficients, full range.
  localparam logic signed [PROD_W-1:0] K_FULL_R_E = PROD_W'(359);
  localparam logic signed [PROD_W-1:0] K_FULL_G_D = PROD_W'(88);
  localparam logic signed [PROD_W-1:0] K_FULL_G_E = PROD_W'(183);
  localparam logic signed [PROD_W-1:0] K_FULL_B_D = PROD_W'(454);

  // 8.8 coefficients, video range.
  localparam logic signed [PROD_W-1:0] K_VID_Y    = PROD_W'(298);
  localparam logic signed [PROD_W-1:0] K_VID_R_E  = PROD_W'(409);
  localparam logic signed [PROD_W-1:0] K_VID_G_D  = PROD_W'(100);
  localparam logic signed [PROD_W-1:0] K_VID_G_E  = PROD_W'(208);
  localparam logic signed [PROD_W-1:0] K_VID_B_D  = PROD_W'(516);

  localparam logic [7:0] CHROMA_BIAS = 8'd128;
  localparam logic [7:0] LUMA_OFFSET = 8'd16;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(128);
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] COMP_MAX = 8'd255;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CHROMA_SWAPPED = 2'd0,
    CFG_FULL_RANGE     = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_first;
    logic [7:0] chroma_second;
  } yuv_pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_pixel_t;

endpackage

`default_nettype wire

// ===== rtl/yuv_bt601_to_rgba_pixel.sv =====
// A pixel accepted at a clock edge passes the input register, then the rgba and done registers together.
// Throughput: one pixel per clock; busy stays low, so start may be held high every cycle.
// Datapath: input register, then products, rounding and saturation straight into rgba.
// Reset (rst, synchronous) empties the pipeline and selects NV12 order and video range.
// The receiver cannot stall: each result is valid for exactly the one cycle done is high.
`default_nettype none

module yuv_bt601_to_rgba_pixel
  import yuv2rgba_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire yuv_pixel_t             yuv,
  output logic                        done,
  output rgba_pixel_t                 rgba,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers.
  logic chroma_swapped;
  logic full_range;

  // Input stage.
  logic       in_vld;
  logic [7:0] in_luma;
  logic [7:0] in_u;
  logic [7:0] in_v;

  // Constant products.
  logic signed [PROD_W-1:0] d_ext;
  logic signed [PROD_W-1:0] e_ext;
  logic signed [PROD_W-1:0] c_ext;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_gd;
  logic signed [PROD_W-1:0] prod_ge;
  logic signed [PROD_W-1:0] prod_b;

  // Rounding and saturation.
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_g;
  logic signed [SUM_W-1:0] sum_b;
  logic signed [SUM_W-1:0] shr_r;
  logic signed [SUM_W-1:0] shr_g;
  logic signed [SUM_W-1:0] shr_b;
  logic signed [RES_W-1:0] luma_ext;
  logic signed [RES_W-1:0] comp_r;
  logic signed [RES_W-1:0] comp_g;
  logic signed [RES_W-1:0] comp_b;
  rgba_pixel_t             rgba_next;

  logic accept;

  function automatic logic [7:0] sat8(input logic signed [RES_W-1:0] val);
    logic [7:0] res;
    if (val < 0) begin
      res = 8'd0;
    end else if (val > $signed(RES_W'(COMP_MAX))) begin
      res = COMP_MAX;
    end else begin
      res = val[7:0];
    end
    return res;
  endfunction

  // The datapath never stalls, so both channels are always open.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      chroma_swapped <= 1'b0;
      full_range     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CHROMA_SWAPPED: chroma_swapped <= cfg_data[0];
        CFG_FULL_RANGE:     full_range     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register; the chroma pair is put into U, V order here.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_luma <= yuv.luma;
      in_u    <= chroma_swapped ? yuv.chroma_second : yuv.chroma_first;
      in_v    <= chroma_swapped ? yuv.chroma_first  : yuv.chroma_second;
    end
  end

  // Constant products. In full range the luma term is zero and luma is added after rounding.
  always_comb begin
    d_ext = $signed(PROD_W'(in_u)) - $signed(PROD_W'(CHROMA_BIAS));
    e_ext = $signed(PROD_W'(in_v)) - $signed(PROD_W'(CHROMA_BIAS));
    c_ext = $signed(PROD_W'(in_luma)) - $signed(PROD_W'(LUMA_OFFSET));
    if (full_range) begin
      prod_y  = '0;
      prod_r  = e_ext * K_FULL_R_E;
      prod_gd = d_ext * K_FULL_G_D;
      prod_ge = e_ext * K_FULL_G_E;
      prod_b  = d_ext * K_FULL_B_D;
    end else begin
      prod_y  = c_ext * K_VID_Y;
      prod_r  = e_ext * K_VID_R_E;
      prod_gd = d_ext * K_VID_G_D;
      prod_ge = e_ext * K_VID_G_E;
      prod_b  = d_ext * K_VID_B_D;
    end
  end

  // The shifts floor toward minus infinity, matching an arithmetic right shift.
  always_comb begin
    luma_ext = $signed(RES_W'(in_luma));
    sum_r = SUM_W'(prod_y) + SUM_W'(prod_r) + ROUND_HALF;
    sum_b = SUM_W'(prod_y) + SUM_W'(prod_b) + ROUND_HALF;
    if (full_range) begin
      sum_g = SUM_W'(prod_gd) + SUM_W'(prod_ge) + ROUND_HALF;
    end else begin
      sum_g = SUM_W'(prod_y) - SUM_W'(prod_gd) - SUM_W'(prod_ge) + ROUND_HALF;
    end
    shr_r = sum_r >>> 8;
    shr_g = sum_g >>> 8;
    shr_b = sum_b >>> 8;
    if (full_range) begin
      comp_r = luma_ext + shr_r[RES_W-1:0];
      comp_g = luma_ext - shr_g[RES_W-1:0];
      comp_b = luma_ext + shr_b[RES_W-1:0];
    end else begin
      comp_r = shr_r[RES_W-1:0];
      comp_g = shr_g[RES_W-1:0];
      comp_b = shr_b[RES_W-1:0];
    end
    rgba_next.red   = sat8(comp_r);
    rgba_next.green = sat8(comp_g);
    rgba_next.blue  = sat8(comp_b);
    rgba_next.alpha = ALPHA_OPAQUE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rgba <= rgba_next;
  end

  // Every accepted transaction produces exactly one strobe, after the input register and the done register.
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("accepted pixel did not produce a result");

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("result strobe without a matching accepted pixel");

  a_alpha_opaque: assert property (@(posedge clk) disable iff (rst)
    done |-> rgba.alpha == ALPHA_OPAQUE)
    else $error("alpha is not opaque");

endmodule

`default_nettype wire
